@@ rtl/mt_seed_draw_matcher_unit_assert.svh @@
// Assertion macros shared by the checker of the seed draw matcher.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MT_SEED_DRAW_MATCHER_UNIT_ASSERT_SVH
`define MT_SEED_DRAW_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define MSDM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msdm port check failed");

// Next-cycle implication, disabled while in reset.
`define MSDM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msdm port check failed");

`endif

@@ rtl/msdm_pkg.sv @@
// Shared constants, types and codes of the MT19937 seed draw matcher.
// No dependencies; used by every module of the block.
package msdm_pkg;

    localparam int WORD_W = 32;
    localparam int HALF_W = 16;

    // MT19937 seeding and twist constants
    localparam logic [WORD_W-1:0] MT_MULT   = 32'd1812433253;
    localparam logic [WORD_W-1:0] MT_UPPER  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MT_LOWER  = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] MT_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] MT_TEMP_B = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] MT_TEMP_C = 32'hefc6_0000;
    localparam int MT_MID = 397;

    // Twist mask for draw k is formed at stage k+1 and used at stage 397+k.
    localparam int MASK_DELAY = MT_MID - 1;

    // Draw check sub-pipeline: temper, fold, reciprocal multiply, compare.
    localparam int CHECK_DEPTH = 4;

    // Configuration
    localparam int CFG_W        = 36;
    localparam int CFG_IDX_W    = 2;
    localparam int TARGET_W     = 4;
    localparam int TARGET_COUNT = 9;

    // Remainder by a small constant divisor (k+2 for draw k, so 2..10 at nine draws):
    // 32-bit value folded to 21 bits, then exact reciprocal multiply.
    localparam int DIV_W       = 5;
    localparam int FOLD_W      = 21;
    localparam int RECIP_SHIFT = FOLD_W + DIV_W;
    localparam int RECIP_W     = RECIP_SHIFT;

    typedef logic [DIV_W-1:0]   div_t;
    typedef logic [FOLD_W-1:0]  fold_t;
    typedef logic [RECIP_W-1:0] recip_t;

    typedef enum logic [1:0] {
        SCAN_INDEX    = 2'd0,
        SCAN_OFFSET   = 2'd1,
        SCAN_FIX_HIGH = 2'd2,
        SCAN_FIX_LOW  = 2'd3
    } scan_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_MODE    = 2'd0,
        REG_SCAN_BASE    = 2'd1,
        REG_FIXED_WORD   = 2'd2,
        REG_DRAW_TARGETS = 2'd3
    } cfg_reg_t;

endpackage

@@ rtl/msdm_init_stage.sv @@
// One MT19937 seeding step as a pipeline stage: word = MULT*(w ^ w>>30) + step.
// Depends on msdm_pkg.
module msdm_init_stage (
    input  logic                        clk,
    input  logic                        en,
    input  logic [msdm_pkg::WORD_W-1:0] step,
    input  logic [msdm_pkg::WORD_W-1:0] prev_word,
    output logic [msdm_pkg::WORD_W-1:0] word,
    output logic [msdm_pkg::WORD_W-1:0] base_word
);

    logic [msdm_pkg::WORD_W-1:0] mixed;
    logic [msdm_pkg::WORD_W-1:0] word_next;
    logic [msdm_pkg::WORD_W-1:0] word_reg;
    logic [msdm_pkg::WORD_W-1:0] base_reg;

    always_comb
    begin
        mixed     = prev_word ^ (prev_word >> 30);
        word_next = msdm_pkg::WORD_W'(mixed * msdm_pkg::MT_MULT) + step;
    end

    // base keeps the previous state word aligned with this one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
            base_reg <= prev_word;
        end
    end

    assign word      = word_reg;
    assign base_word = base_reg;

endmodule

@@ rtl/msdm_draw_check.sv @@
// Check of one draw: twist mask delay line, tempering, remainder by a constant
// divisor and compare with the target. Depends on msdm_pkg.
module msdm_draw_check (
    input  logic                          clk,
    input  logic                          en,
    input  msdm_pkg::div_t                divisor,
    input  msdm_pkg::div_t                fold,
    input  msdm_pkg::recip_t              recip,
    input  logic [msdm_pkg::WORD_W-1:0]   head_word,
    input  logic [msdm_pkg::WORD_W-1:0]   next_head_word,
    input  logic [msdm_pkg::WORD_W-1:0]   mid_word,
    input  logic [msdm_pkg::TARGET_W-1:0] target,
    output logic                          ok
);

    localparam int PROD_W = msdm_pkg::FOLD_W + msdm_pkg::RECIP_W;

    function automatic logic [msdm_pkg::WORD_W-1:0] temper(
        input logic [msdm_pkg::WORD_W-1:0] y_in
    );
        logic [msdm_pkg::WORD_W-1:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & msdm_pkg::MT_TEMP_B);
        y = y ^ ((y << 15) & msdm_pkg::MT_TEMP_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    logic [msdm_pkg::WORD_W-1:0] joined;
    logic [msdm_pkg::WORD_W-1:0] mask_next;
    logic [msdm_pkg::WORD_W-1:0] mask_line_reg [0:msdm_pkg::MASK_DELAY-1];

    logic [msdm_pkg::WORD_W-1:0] temp_next;
    logic [msdm_pkg::WORD_W-1:0] temp_reg;
    msdm_pkg::fold_t             fold_next;
    msdm_pkg::fold_t             fold_reg;
    logic [PROD_W-1:0]           prod;
    msdm_pkg::fold_t             quot_next;
    msdm_pkg::fold_t             quot_reg;
    msdm_pkg::fold_t             rem_base_reg;
    msdm_pkg::fold_t             rem;
    logic                        ok_next;
    logic                        ok_reg;

    always_comb
    begin
        joined    = (head_word & msdm_pkg::MT_UPPER) | (next_head_word & msdm_pkg::MT_LOWER);
        mask_next = (joined >> 1) ^ (joined[0] ? msdm_pkg::MT_MATRIX : '0);
        temp_next = temper(mid_word ^ mask_line_reg[msdm_pkg::MASK_DELAY-1]);
        // 2^16 mod d folds the high half into a 21-bit value with the same remainder
        fold_next = msdm_pkg::fold_t'({5'b0, temp_reg[31:16]} * {16'b0, fold})
                  + msdm_pkg::fold_t'(temp_reg[15:0]);
        prod      = PROD_W'(fold_reg) * PROD_W'(recip);
        quot_next = prod[PROD_W-1:msdm_pkg::RECIP_SHIFT];
        rem       = rem_base_reg - quot_reg * msdm_pkg::fold_t'(divisor);
        ok_next   = (rem == msdm_pkg::fold_t'(target));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mask_line_reg[0] <= mask_next;
            for (int j = 1; j < msdm_pkg::MASK_DELAY; j++)
            begin
                mask_line_reg[j] <= mask_line_reg[j-1];
            end
            temp_reg     <= temp_next;
            fold_reg     <= fold_next;
            quot_reg     <= quot_next;
            rem_base_reg <= fold_reg;
            ok_reg       <= ok_next;
        end
    end

    assign ok = ok_reg;

endmodule

@@ rtl/mt_seed_draw_matcher_unit.sv @@
// MT19937 seed draw matcher: top level, pipeline control and output skid.
// Depends on msdm_pkg, msdm_init_stage and msdm_draw_check.
//
// Usage:
//   Input channel index_valid/index_ready/seed_index takes one scan index per
//   word. The seed is formed from it by scan_mode, then checked against nine
//   (DRAW_COUNT) tempered MT19937 draws; output channel result_valid/
//   result_ready/seed/match returns the seed and the match flag, in order.
//   Throughput: one word per cycle unless the output stalls. Every seeding
//   step is its own stage with one 32x32 multiplier, so the pipeline is as
//   deep as the seeding chain: 396+DRAW_COUNT steps plus a 4-stage check per
//   draw. An accepted word runs through stage 0, the seeding chain, the draw
//   checks and the fail merge into the output register.
//   Config port: cfg_we/cfg_index/cfg_data write one of scan_mode, the scan
//   base, fixed_word and draw_targets, chosen by cfg_index; write only while idle.
//   Reset: all pipeline valids clear, config registers go to 0, ready comes up at once.
//   Stall: when result_ready is low the output holds its word and one more
//   word is parked in a skid register; index_ready then drops and the whole
//   pipeline freezes, losing nothing. index_ready comes from a register.
module mt_seed_draw_matcher_unit #(
    parameter int DRAW_COUNT = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [msdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [msdm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           index_valid,
    output logic                           index_ready,
    input  logic [msdm_pkg::WORD_W-1:0]    seed_index,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [msdm_pkg::WORD_W-1:0]    seed,
    output logic                           match
);

    // stage s (1..INIT_STEPS) holds state word s of the seeding chain
    localparam int INIT_STEPS = msdm_pkg::MT_MID - 1 + DRAW_COUNT;
    // last stage: check of the last draw plus the fail merge
    localparam int LAST = msdm_pkg::MT_MID + msdm_pkg::CHECK_DEPTH + DRAW_COUNT;

    // configuration registers
    msdm_pkg::scan_mode_t              scan_mode_reg;
    logic [msdm_pkg::WORD_W-1:0]       scan_base_reg;
    logic [msdm_pkg::HALF_W-1:0]       fixed_word_reg;
    logic [msdm_pkg::CFG_W-1:0]        draw_targets_reg;

    // pipeline
    logic                              adv;
    logic [msdm_pkg::WORD_W-1:0]       seed_next;
    logic [LAST:0]                     valid_reg;
    logic [msdm_pkg::WORD_W-1:0]       seed_reg [0:LAST];
    logic [msdm_pkg::WORD_W-1:0]       chain_word [0:INIT_STEPS];
    logic [msdm_pkg::WORD_W-1:0]       head_base [1:DRAW_COUNT];
    logic [DRAW_COUNT-1:0]             draw_ok;
    logic [DRAW_COUNT-1:0]             fail_reg;

    // output register and skid
    logic                              pop;
    logic                              push;
    logic                              result_valid_reg;
    logic                              result_valid_next;
    logic [msdm_pkg::WORD_W-1:0]       out_seed_reg;
    logic [msdm_pkg::WORD_W-1:0]       out_seed_next;
    logic                              out_match_reg;
    logic                              out_match_next;
    logic                              skid_valid_reg;
    logic                              skid_valid_next;
    logic [msdm_pkg::WORD_W-1:0]       skid_seed_reg;
    logic [msdm_pkg::WORD_W-1:0]       skid_seed_next;
    logic                              skid_match_reg;
    logic                              skid_match_next;

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg    <= msdm_pkg::SCAN_INDEX;
            scan_base_reg    <= '0;
            fixed_word_reg   <= '0;
            draw_targets_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (msdm_pkg::cfg_reg_t'(cfg_index))
                msdm_pkg::REG_SCAN_MODE:
                    scan_mode_reg <= msdm_pkg::scan_mode_t'(cfg_data[1:0]);
                msdm_pkg::REG_SCAN_BASE:
                    scan_base_reg <= cfg_data[msdm_pkg::WORD_W-1:0];
                msdm_pkg::REG_FIXED_WORD:
                    fixed_word_reg <= cfg_data[msdm_pkg::HALF_W-1:0];
                msdm_pkg::REG_DRAW_TARGETS:
                    draw_targets_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: seed formation
    // ---------------------------------------------------------------
    always_comb
    begin
        case (scan_mode_reg)
            msdm_pkg::SCAN_INDEX:    seed_next = seed_index;
            msdm_pkg::SCAN_OFFSET:   seed_next = scan_base_reg + seed_index;
            msdm_pkg::SCAN_FIX_HIGH: seed_next = {fixed_word_reg, seed_index[15:0]};
            msdm_pkg::SCAN_FIX_LOW:  seed_next = {seed_index[15:0], fixed_word_reg};
            default:                 seed_next = seed_index;
        endcase
    end

    // whole pipeline moves as one; held only while the skid is occupied
    assign adv         = ~skid_valid_reg;
    assign index_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAST-1:0], index_valid};
        end
    end

    // seed rides along with every word; fail bit k joins at stage 402+k
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            seed_reg[0] <= seed_next;
            for (int s = 1; s <= LAST; s++)
            begin
                seed_reg[s] <= seed_reg[s-1];
            end
            fail_reg[0] <= ~draw_ok[0];
            for (int k = 1; k < DRAW_COUNT; k++)
            begin
                fail_reg[k] <= fail_reg[k-1] | ~draw_ok[k];
            end
        end
    end

    assign chain_word[0] = seed_reg[0];

    // ---------------------------------------------------------------
    // Seeding chain: one multiply per stage
    // ---------------------------------------------------------------
    for (genvar s = 1; s <= INIT_STEPS; s++)
    begin : g_init
        if (s <= DRAW_COUNT)
        begin : g_head
            msdm_init_stage u_stage (
                .clk       (clk),
                .en        (adv),
                .step      (msdm_pkg::WORD_W'(s)),
                .prev_word (chain_word[s-1]),
                .word      (chain_word[s]),
                .base_word (head_base[s])
            );
        end
        else
        begin : g_body
            msdm_init_stage u_stage (
                .clk       (clk),
                .en        (adv),
                .step      (msdm_pkg::WORD_W'(s)),
                .prev_word (chain_word[s-1]),
                .word      (chain_word[s]),
                .base_word ()
            );
        end
    end

    // ---------------------------------------------------------------
    // Draw checks: mask from state words k and k+1 (stage k+1),
    // twisted with state word 397+k, remainder by k+2.
    // ---------------------------------------------------------------
    for (genvar k = 0; k < DRAW_COUNT; k++)
    begin : g_draw
        localparam int DIV   = k + 2;
        localparam int FOLD  = (2 ** msdm_pkg::HALF_W) % DIV;
        localparam int RECIP = ((2 ** msdm_pkg::RECIP_SHIFT) + DIV - 1) / DIV;

        logic [msdm_pkg::TARGET_W-1:0] target;

        // only nine targets exist; later draws compare against zero
        if (k < msdm_pkg::TARGET_COUNT)
        begin : g_tgt
            assign target = draw_targets_reg[msdm_pkg::TARGET_W*k +: msdm_pkg::TARGET_W];
        end
        else
        begin : g_zero
            assign target = '0;
        end

        msdm_draw_check u_check (
            .clk            (clk),
            .en             (adv),
            .divisor        (msdm_pkg::div_t'(DIV)),
            .fold           (msdm_pkg::div_t'(FOLD)),
            .recip          (msdm_pkg::recip_t'(RECIP)),
            .head_word      (head_base[k+1]),
            .next_head_word (chain_word[k+1]),
            .mid_word       (chain_word[msdm_pkg::MT_MID+k]),
            .target         (target),
            .ok             (draw_ok[k])
        );
    end

    // ---------------------------------------------------------------
    // Output register with one-word skid
    // ---------------------------------------------------------------
    assign pop  = result_valid_reg & result_ready;
    assign push = adv & valid_reg[LAST];

    always_comb
    begin
        result_valid_next = result_valid_reg;
        out_seed_next     = out_seed_reg;
        out_match_next    = out_match_reg;
        skid_valid_next   = skid_valid_reg;
        skid_seed_next    = skid_seed_reg;
        skid_match_next   = skid_match_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_seed_next   = skid_seed_reg;
                out_match_next  = skid_match_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!result_valid_reg || pop)
            begin
                result_valid_next = 1'b1;
                out_seed_next     = seed_reg[LAST];
                out_match_next    = ~fail_reg[DRAW_COUNT-1];
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_seed_next  = seed_reg[LAST];
                skid_match_next = ~fail_reg[DRAW_COUNT-1];
            end
        end
        else if (pop)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_seed_reg   <= out_seed_next;
        out_match_reg  <= out_match_next;
        skid_seed_reg  <= skid_seed_next;
        skid_match_reg <= skid_match_next;
    end

    assign result_valid = result_valid_reg;
    assign seed         = out_seed_reg;
    assign match        = out_match_reg;

endmodule

@@ rtl/msdm_port_checker.sv @@
// Port-level checks of the seed draw matcher, bound to the top level.
// Depends on msdm_pkg and mt_seed_draw_matcher_unit_assert.svh.
`include "mt_seed_draw_matcher_unit_assert.svh"

module msdm_port_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          index_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [msdm_pkg::WORD_W-1:0]   seed,
    input logic                          match
);

    // stalled result word holds
    `MSDM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(seed) && $stable(match))

    // with the output empty the skid is empty too, so input is open
    `MSDM_ASSERT_NOW(a_ready_when_empty, !result_valid, index_ready)

    // ready drops only after a stalled output cycle
    `MSDM_ASSERT_NOW(a_ready_falls_on_stall, $fell(index_ready), $past(result_valid && !result_ready))

    // pipeline stays frozen while the output keeps stalling
    `MSDM_ASSERT_NEXT(a_stall_keeps_closed, !index_ready && !result_ready, !index_ready)

endmodule

bind mt_seed_draw_matcher_unit msdm_port_checker u_port_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .index_ready  (index_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .seed         (seed),
    .match        (match)
);

@@ dv/tb.sv @@
// Self-checking testbench for mt_seed_draw_matcher_unit.
// Depends on msdm_pkg and the block's RTL; it predicts every result word from
// its own copy of the registers and checks results in order.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAW_COUNT  = 9;
    localparam int RESID_W     = msdm_pkg::TARGET_W * DRAW_COUNT;
    // Pipeline is 411 deep at nine draws; wait a little longer at the end.
    localparam int DRAIN_WAIT  = DRAW_COUNT + 450;
    localparam int HOLDOFF_LEN = 800;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [msdm_pkg::WORD_W-1:0] seed;
        logic                        match;
    } draw_result_t;

    // DUT ports
    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_we       = 1'b0;
    logic [msdm_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [msdm_pkg::CFG_W-1:0]     cfg_data     = '0;
    logic                           index_valid  = 1'b0;
    logic                           index_ready;
    logic [msdm_pkg::WORD_W-1:0]    seed_index   = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    logic [msdm_pkg::WORD_W-1:0]    seed;
    logic                           match;

    // Shadow copy of the block's registers
    msdm_pkg::scan_mode_t           cur_mode    = msdm_pkg::SCAN_INDEX;
    logic [msdm_pkg::WORD_W-1:0]    cur_start   = '0;
    logic [msdm_pkg::HALF_W-1:0]    cur_fixed   = '0;
    logic [RESID_W-1:0]             cur_targets = '0;

    // Stimulus and scoreboard state
    logic [msdm_pkg::WORD_W-1:0]    pending_index[$];
    draw_result_t                   predicted_results[$];
    draw_result_t                   oldest_result;
    logic                           index_taken    = 1'b0;
    int unsigned                    send_idle_pct  = 0;
    int unsigned                    recv_stall_pct = 0;
    bit                             holdoff_req    = 1'b0;
    int unsigned                    holdoff_left   = 0;
    int unsigned                    fail_count     = 0;
    int unsigned                    cycle_count    = 0;

    mt_seed_draw_matcher_unit #(
        .DRAW_COUNT(DRAW_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .index_valid (index_valid),
        .index_ready (index_ready),
        .seed_index  (seed_index),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .seed        (seed),
        .match       (match)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One step of MT19937 seeding: next state word from the previous one.
    function automatic logic [msdm_pkg::WORD_W-1:0] init_word(
        input logic [msdm_pkg::WORD_W-1:0] prev,
        input int unsigned                 pos
    );
        return msdm_pkg::MT_MULT * (prev ^ (prev >> 30)) + msdm_pkg::WORD_W'(pos);
    endfunction

    function automatic logic [msdm_pkg::WORD_W-1:0] temper_word(
        input logic [msdm_pkg::WORD_W-1:0] x
    );
        logic [msdm_pkg::WORD_W-1:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & msdm_pkg::MT_TEMP_B);
        y = y ^ ((y << 15) & msdm_pkg::MT_TEMP_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Candidate seed from a scan index under the current mode.
    function automatic logic [msdm_pkg::WORD_W-1:0] form_candidate(
        input logic [msdm_pkg::WORD_W-1:0] idx
    );
        case (cur_mode)
            msdm_pkg::SCAN_INDEX:    return idx;
            msdm_pkg::SCAN_OFFSET:   return cur_start + idx;   // wraps mod 2^32
            msdm_pkg::SCAN_FIX_HIGH: return {cur_fixed, idx[msdm_pkg::HALF_W-1:0]};
            default:                 return {idx[msdm_pkg::HALF_W-1:0], cur_fixed};
        endcase
    endfunction

    // Remainder of each tempered draw, packed like draw_targets. Every nibble
    // is below k+2, so an out-of-range target can never compare equal.
    function automatic logic [RESID_W-1:0] draw_residues(
        input logic [msdm_pkg::WORD_W-1:0] s
    );
        logic [msdm_pkg::WORD_W-1:0] head [0:DRAW_COUNT];
        logic [msdm_pkg::WORD_W-1:0] w;
        logic [msdm_pkg::WORD_W-1:0] joined;
        logic [msdm_pkg::WORD_W-1:0] tw;
        logic [msdm_pkg::WORD_W-1:0] y;
        logic [RESID_W-1:0]          r;
        int unsigned                 i;
        head[0] = s;
        w = s;
        r = '0;
        for (i = 1; i <= msdm_pkg::MT_MID; i++)
        begin
            w = init_word(w, i);
            if (i <= DRAW_COUNT)
                head[i] = w;
        end
        // w is now state word 397
        for (i = 0; i < DRAW_COUNT; i++)
        begin
            joined = (head[i] & msdm_pkg::MT_UPPER) | (head[i+1] & msdm_pkg::MT_LOWER);
            tw = w ^ (joined >> 1);
            if (joined[0])
                tw = tw ^ msdm_pkg::MT_MATRIX;
            y = temper_word(tw);
            r[msdm_pkg::TARGET_W*i +: msdm_pkg::TARGET_W] = msdm_pkg::TARGET_W'(y % (i + 2));
            w = init_word(w, msdm_pkg::MT_MID + 1 + i);
        end
        return r;
    endfunction

    function automatic draw_result_t predict_result(input logic [msdm_pkg::WORD_W-1:0] idx);
        draw_result_t res;
        res.seed  = form_candidate(idx);
        res.match = (draw_residues(res.seed) == cur_targets);
        return res;
    endfunction

    // Queue one scan index at the tail of the sender's queue.
    task automatic enqueue_index(input logic [msdm_pkg::WORD_W-1:0] v);
        pending_index.insert(pending_index.size(), v);
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver, monitor
    // ------------------------------------------------------------------

    // Acceptance of input words; the prediction is made with the registers
    // as they stand, which only change while nothing is in flight.
    always @(posedge clk)
    begin
        index_taken <= rst_n && index_valid && index_ready;
        if (rst_n && index_valid && index_ready)
            predicted_results.insert(predicted_results.size(), predict_result(seed_index));
    end

    // Sender: holds a word until taken, then maybe idles before the next one.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            index_valid <= 1'b0;
        end
        else if (index_valid && !index_taken)
        begin
            // word still waiting, keep it steady
        end
        else if (pending_index.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            index_valid <= 1'b1;
            seed_index  <= pending_index.pop_front();
        end
        else
        begin
            index_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted here once armed.
    always @(posedge clk)
    begin
        if (holdoff_req)
            holdoff_left <= HOLDOFF_LEN;
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Receiver: random stalls plus the hold-off.
    always @(negedge clk)
    begin
        result_ready <= rst_n && (holdoff_left == 0) &&
                        ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker: in-order compare against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                if (fail_count < 10)
                    $display("ERROR: result word with nothing expected: seed %h match %b",
                             seed, match);
                fail_count++;
            end
            else
            begin
                oldest_result = predicted_results.pop_front();
                if (seed !== oldest_result.seed || match !== oldest_result.match)
                begin
                    if (fail_count < 10)
                        $display("ERROR: expected seed %h match %b, got seed %h match %b",
                                 oldest_result.seed, oldest_result.match, seed, match);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("mt_seed_draw_matcher_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus control
    // ------------------------------------------------------------------

    // Idle pattern: 0 none, 1 sender idle, 2 receiver stalls, 3 both light.
    task automatic set_pattern(input int unsigned p);
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
    endtask

    // Block until no word is queued, offered or in flight.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_index.size() != 0 || index_valid || predicted_results.size() != 0);
    endtask

    // Register write; narrow registers sometimes get junk in the unused bits.
    task automatic write_cfg(input msdm_pkg::cfg_reg_t idx,
                             input logic [msdm_pkg::CFG_W-1:0] value);
        logic [msdm_pkg::CFG_W-1:0] data;
        logic [msdm_pkg::CFG_W-1:0] junk;
        data = value;
        junk = msdm_pkg::CFG_W'({$urandom, $urandom});
        if ($urandom_range(0, 1))
        begin
            case (idx)
                msdm_pkg::REG_SCAN_MODE:
                    data = data | (junk & ~msdm_pkg::CFG_W'(2'b11));
                msdm_pkg::REG_SCAN_BASE:
                    data = data | (junk & ~msdm_pkg::CFG_W'(32'hffff_ffff));
                msdm_pkg::REG_FIXED_WORD:
                    data = data | (junk & ~msdm_pkg::CFG_W'(16'hffff));
                default: ;
            endcase
        end
        case (idx)
            msdm_pkg::REG_SCAN_MODE:  cur_mode  = msdm_pkg::scan_mode_t'(value[1:0]);
            msdm_pkg::REG_SCAN_BASE:  cur_start = value[msdm_pkg::WORD_W-1:0];
            msdm_pkg::REG_FIXED_WORD: cur_fixed = value[msdm_pkg::HALF_W-1:0];
            default:                  cur_targets = value[RESID_W-1:0];
        endcase
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random scan index: mostly around the anchor that the targets were
    // built from, so matches are common, the rest wide random.
    function automatic logic [msdm_pkg::WORD_W-1:0] pick_index(
        input logic [msdm_pkg::WORD_W-1:0] anchor
    );
        case ($urandom_range(0, 9))
            0, 1, 2: return anchor;
            3:       return {~anchor[msdm_pkg::WORD_W-1:msdm_pkg::HALF_W],
                             anchor[msdm_pkg::HALF_W-1:0]};
            4:       return anchor + msdm_pkg::WORD_W'($urandom_range(1, 3));
            5:       return $urandom_range(0, 1) ? '0 : '1;
            default: return $urandom;
        endcase
    endfunction

    // New register setting with targets built from one anchor index.
    task automatic random_setting(output logic [msdm_pkg::WORD_W-1:0] anchor);
        logic [RESID_W-1:0] tgt;
        int unsigned        k;
        case ($urandom_range(0, 2))
            0:       write_cfg(msdm_pkg::REG_SCAN_BASE, '0);
            1:       write_cfg(msdm_pkg::REG_SCAN_BASE, msdm_pkg::CFG_W'(32'hffff_ffff));
            default: write_cfg(msdm_pkg::REG_SCAN_BASE, msdm_pkg::CFG_W'($urandom));
        endcase
        case ($urandom_range(0, 2))
            0:       write_cfg(msdm_pkg::REG_FIXED_WORD, '0);
            1:       write_cfg(msdm_pkg::REG_FIXED_WORD, msdm_pkg::CFG_W'(16'hffff));
            default: write_cfg(msdm_pkg::REG_FIXED_WORD,
                               msdm_pkg::CFG_W'($urandom_range(0, 16'hffff)));
        endcase
        write_cfg(msdm_pkg::REG_SCAN_MODE, msdm_pkg::CFG_W'($urandom_range(0, 3)));
        anchor = $urandom;
        tgt = draw_residues(form_candidate(anchor));
        case ($urandom_range(0, 5))
            0:
            begin
                // one draw off target, possibly out of reach
                k = $urandom_range(0, DRAW_COUNT - 1);
                tgt[msdm_pkg::TARGET_W*k +: msdm_pkg::TARGET_W] =
                    msdm_pkg::TARGET_W'($urandom_range(0, 15));
            end
            1:       tgt = RESID_W'({$urandom, $urandom});
            default: ;
        endcase
        write_cfg(msdm_pkg::REG_DRAW_TARGETS, msdm_pkg::CFG_W'(tgt));
    endtask

    initial
    begin : stimulus
        logic [msdm_pkg::WORD_W-1:0] anchor;
        logic [RESID_W-1:0]          tgt;
        int unsigned                 ph;
        int unsigned                 n;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part, no idling ----
        set_pattern(0);

        // Reset setting: seed is the index, all targets zero.
        enqueue_index('0);
        enqueue_index('1);
        enqueue_index(32'h8000_0000);
        wait_drained();

        // Start plus index, wrapping past 2^32.
        write_cfg(msdm_pkg::REG_SCAN_MODE, msdm_pkg::CFG_W'(msdm_pkg::SCAN_OFFSET));
        write_cfg(msdm_pkg::REG_SCAN_BASE, msdm_pkg::CFG_W'(32'hffff_fff0));
        enqueue_index(32'h0000_0010);
        enqueue_index(32'hffff_ffff);
        enqueue_index(32'h0000_0005);
        wait_drained();

        // Fixed high half; upper index bits must be ignored.
        write_cfg(msdm_pkg::REG_SCAN_MODE, msdm_pkg::CFG_W'(msdm_pkg::SCAN_FIX_HIGH));
        write_cfg(msdm_pkg::REG_FIXED_WORD, msdm_pkg::CFG_W'(16'hffff));
        enqueue_index(32'habcd_1234);
        enqueue_index(32'h0000_ffff);
        enqueue_index(32'hffff_0000);
        wait_drained();

        // Fixed low half, all-ones targets: every draw out of reach.
        write_cfg(msdm_pkg::REG_SCAN_MODE, msdm_pkg::CFG_W'(msdm_pkg::SCAN_FIX_LOW));
        write_cfg(msdm_pkg::REG_FIXED_WORD, '0);
        write_cfg(msdm_pkg::REG_DRAW_TARGETS, '1);
        enqueue_index(32'h1234_ffff);
        enqueue_index(32'hffff_0001);
        wait_drained();

        // A seed whose targets are its own draws: match, and the same low
        // half with other upper bits still matches.
        tgt = draw_residues(form_candidate(32'h0000_1571));
        write_cfg(msdm_pkg::REG_DRAW_TARGETS, msdm_pkg::CFG_W'(tgt));
        enqueue_index(32'h0000_1571);
        enqueue_index(32'hdead_1571);
        enqueue_index(32'h0000_1572);
        wait_drained();

        write_cfg(msdm_pkg::REG_SCAN_MODE, msdm_pkg::CFG_W'(msdm_pkg::SCAN_INDEX));
        tgt = draw_residues(32'd5489);
        write_cfg(msdm_pkg::REG_DRAW_TARGETS, msdm_pkg::CFG_W'(tgt));
        enqueue_index(32'd5489);
        enqueue_index(32'd5490);
        wait_drained();

        // Draw 0 target of 2 can never be met.
        tgt[msdm_pkg::TARGET_W-1:0] = msdm_pkg::TARGET_W'(2);
        write_cfg(msdm_pkg::REG_DRAW_TARGETS, msdm_pkg::CFG_W'(tgt));
        enqueue_index(32'd5489);
        // Last draw target of 10 can never be met either.
        wait_drained();
        tgt = draw_residues(32'd5489);
        tgt[msdm_pkg::TARGET_W*(DRAW_COUNT-1) +: msdm_pkg::TARGET_W] =
            msdm_pkg::TARGET_W'(DRAW_COUNT + 1);
        write_cfg(msdm_pkg::REG_DRAW_TARGETS, msdm_pkg::CFG_W'(tgt));
        enqueue_index(32'd5489);
        wait_drained();

        // ---- pressure: receiver holds off while the sender keeps offering,
        // so the pipeline and skid fill and index_ready drops ----
        set_pattern(0);
        random_setting(anchor);
        @(negedge clk);
        holdoff_req = 1'b1;
        @(posedge clk);
        @(negedge clk);
        holdoff_req = 1'b0;
        for (n = 0; n < 432; n++)
            enqueue_index(pick_index(anchor));
        // sender pauses here until every result is back
        wait_drained();

        // ---- random phases over all idle patterns ----
        for (ph = 0; ph < 8; ph++)
        begin
            set_pattern(ph);
            random_setting(anchor);
            for (n = 0; n < 25; n++)
                enqueue_index(pick_index(anchor));
            // short pause mid-phase so gaps also land on a refilling pipe
            if (ph % 2 == 1)
            begin
                wait_drained();
            end
            for (n = 0; n < 25; n++)
                enqueue_index(pick_index(anchor));
            wait_drained();
        end

        // Trailing window: any extra word now is a failure.
        set_pattern(0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && predicted_results.size() == 0)
            $display("mt_seed_draw_matcher_unit verification clean");
        else
            $display("mt_seed_draw_matcher_unit verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/msdm_pkg.sv
rtl/msdm_init_stage.sv
rtl/msdm_draw_check.sv
rtl/mt_seed_draw_matcher_unit.sv
rtl/msdm_port_checker.sv
dv/tb.sv
